FILE: rtl/core/lfade_pkg.sv
// ----------------------------------------------------------------------------
// lfade_pkg
// Shared types and constants of the LED fader with auto-off timer.
// ----------------------------------------------------------------------------
`default_nettype none

package lfade_pkg;

  localparam logic [7:0] FULL_LEVEL = 8'd255;

  // Register indexes on the configuration port (word address)
  localparam logic [1:0] REG_FADE_STEP     = 2'd0;
  localparam logic [1:0] REG_MAX_LEVEL     = 2'd1;
  localparam logic [1:0] REG_FADE_INTERVAL = 2'd2;
  localparam logic [1:0] REG_AUTO_TIMEOUT  = 2'd3;

  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_SET    = 3'd1,
    CMD_MANUAL = 3'd2,
    CMD_AUTO   = 3'd3,
    CMD_TOGGLE = 3'd4,
    CMD_ON     = 3'd5,
    CMD_OFF    = 3'd6
  } cmd_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_COUNT,
    OP_STEP,
    OP_DIV,
    OP_GOAL,
    OP_APPLY
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   load;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_stat_t;

  typedef struct packed {
    logic [7:0]  fade_step;
    logic [7:0]  max_level;
    logic [15:0] fade_interval;
    logic [31:0] auto_timeout;
  } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/core/lfade_regs.sv
// ----------------------------------------------------------------------------
// lfade_regs
// Configuration register file behind an APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module lfade_regs
  import lfade_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fade_step     <= 8'd5;
      cfg.max_level     <= 8'd255;
      cfg.fade_interval <= 16'd10;
      cfg.auto_timeout  <= 32'd60000;
    end else if (wr_en) begin
      case (idx)
        REG_FADE_STEP:     cfg.fade_step     <= pwdata[7:0];
        REG_MAX_LEVEL:     cfg.max_level     <= pwdata[7:0];
        REG_FADE_INTERVAL: cfg.fade_interval <= pwdata[15:0];
        REG_AUTO_TIMEOUT:  cfg.auto_timeout  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FADE_STEP:     prdata = {24'd0, cfg.fade_step};
      REG_MAX_LEVEL:     prdata = {24'd0, cfg.max_level};
      REG_FADE_INTERVAL: prdata = {16'd0, cfg.fade_interval};
      REG_AUTO_TIMEOUT:  prdata = cfg.auto_timeout;
      default:           prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/lfade_ctrl.sv
// ----------------------------------------------------------------------------
// lfade_ctrl
// Sequencer: steps each command through the datapath and owns the handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module lfade_ctrl
  import lfade_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  input  wire cmd_t     in_cmd,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COUNT,
    ST_STEP,
    ST_DIV,
    ST_GOAL,
    ST_APPLY,
    ST_EMIT
  } state_t;

  state_t state;

  always_comb begin
    cmd      = '{op: OP_NONE, load: 1'b0, out_load: 1'b0};
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_COUNT: cmd.op = OP_COUNT;
      ST_STEP:  cmd.op = OP_STEP;
      ST_DIV:   cmd.op = OP_DIV;
      ST_GOAL:  cmd.op = OP_GOAL;
      ST_APPLY: cmd.op = OP_APPLY;
      ST_EMIT:  cmd.out_load = ~out_valid | out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_EMIT && cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            case (in_cmd)
              CMD_TICK:            state <= ST_COUNT;
              CMD_SET, CMD_TOGGLE: state <= ST_DIV;
              default:             state <= ST_APPLY;
            endcase
          end
        end
        ST_COUNT: state <= ST_STEP;
        ST_STEP:  state <= ST_EMIT;
        ST_DIV:   if (stat.div_last) state <= ST_GOAL;
        ST_GOAL:  state <= ST_EMIT;
        ST_APPLY: state <= ST_EMIT;
        ST_EMIT: begin
          // hold until the output register is free
          if (cmd.out_load) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/lfade_dp.sv
// ----------------------------------------------------------------------------
// lfade_dp
// Datapath: fader state, tick counters, bit-serial rounding, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lfade_dp
  import lfade_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire dp_cmd_t    cmd,
  output dp_stat_t        stat,
  input  wire cmd_t       in_command,
  input  wire logic [7:0] in_target,
  input  wire cfg_t       cfg,
  output logic      [7:0] level,
  output logic      [7:0] target_level,
  output logic            fading,
  output logic            auto_armed,
  output logic            manual_hold
);

  cmd_t        cmd_q;
  logic [7:0]  div_num;
  logic [7:0]  rem;
  logic [2:0]  div_cnt;

  logic [7:0]  level_now,   level_now_next;
  logic [7:0]  level_goal,  level_goal_next;
  logic        fade_on,     fade_on_next;
  logic [15:0] fade_ticks,  fade_ticks_next;
  logic        auto_on,     auto_on_next;
  logic [31:0] auto_ticks,  auto_ticks_next;
  logic        hold_manual, hold_manual_next;

  logic [7:0]  step;
  logic [8:0]  trial;
  logic [8:0]  trial_sub;
  logic [31:0] auto_inc;
  logic [7:0]  step_level;

  assign step      = (cfg.fade_step == 8'd0) ? 8'd1 : cfg.fade_step;
  assign trial     = {rem, div_num[3'd7 - div_cnt]};
  assign trial_sub = trial - {1'b0, step};
  assign auto_inc  = (auto_ticks != 32'hFFFF_FFFF) ? auto_ticks + 32'd1 : auto_ticks;
  assign stat.div_last = (div_cnt == 3'd7);

  // one fade step toward the goal, snapping onto it when within a step
  always_comb begin
    step_level = level_now;
    if (level_now < level_goal) begin
      step_level = ((level_goal - level_now) <= step) ? level_goal : level_now + step;
    end else if (level_now > level_goal) begin
      step_level = ((level_now - level_goal) <= step) ? level_goal : level_now - step;
    end
  end

  always_comb begin
    level_now_next   = level_now;
    level_goal_next  = level_goal;
    fade_on_next     = fade_on;
    fade_ticks_next  = fade_ticks;
    auto_on_next     = auto_on;
    auto_ticks_next  = auto_ticks;
    hold_manual_next = hold_manual;
    case (cmd.op)
      OP_COUNT: begin
        if (fade_on && fade_ticks != 16'hFFFF) fade_ticks_next = fade_ticks + 16'd1;
        if (auto_on) begin
          auto_ticks_next = auto_inc;
          if (auto_inc >= cfg.auto_timeout) begin
            level_goal_next  = 8'd0;
            fade_on_next     = 1'b1;
            fade_ticks_next  = 16'd0;
            auto_on_next     = 1'b0;
            hold_manual_next = 1'b1;
          end
        end
      end
      OP_STEP: begin
        if (fade_on && fade_ticks >= cfg.fade_interval) begin
          level_now_next  = step_level;
          fade_ticks_next = 16'd0;
          if (step_level == level_goal) begin
            fade_on_next     = 1'b0;
            hold_manual_next = 1'b0;
          end
        end
      end
      OP_GOAL: begin
        level_goal_next = div_num - rem;
        if (cmd_q == CMD_TOGGLE) begin
          fade_on_next     = 1'b1;
          fade_ticks_next  = 16'd0;
          auto_on_next     = 1'b0;
          hold_manual_next = 1'b1;
        end
      end
      OP_APPLY: begin
        case (cmd_q)
          CMD_MANUAL, CMD_AUTO: begin
            fade_on_next    = 1'b1;
            fade_ticks_next = 16'd0;
            if (cmd_q == CMD_AUTO && !hold_manual) begin
              auto_on_next     = 1'b1;
              auto_ticks_next  = 32'd0;
              hold_manual_next = 1'b0;
            end else begin
              auto_on_next     = 1'b0;
              hold_manual_next = 1'b1;
            end
          end
          CMD_ON:  level_now_next = FULL_LEVEL;
          CMD_OFF: level_now_next = 8'd0;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level_now   <= 8'd0;
      level_goal  <= 8'd0;
      fade_on     <= 1'b0;
      fade_ticks  <= 16'd0;
      auto_on     <= 1'b0;
      auto_ticks  <= 32'd0;
      hold_manual <= 1'b0;
    end else begin
      level_now   <= level_now_next;
      level_goal  <= level_goal_next;
      fade_on     <= fade_on_next;
      fade_ticks  <= fade_ticks_next;
      auto_on     <= auto_on_next;
      auto_ticks  <= auto_ticks_next;
      hold_manual <= hold_manual_next;
    end
  end

  // clamped value to round, then one remainder bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q   <= in_command;
      rem     <= 8'd0;
      div_cnt <= 3'd0;
      if (in_command == CMD_TOGGLE) begin
        div_num <= (level_goal != 8'd0) ? 8'd0 : cfg.max_level;
      end else begin
        div_num <= (in_target > cfg.max_level) ? cfg.max_level : in_target;
      end
    end else if (cmd.op == OP_DIV) begin
      rem     <= trial_sub[8] ? trial[7:0] : trial_sub[7:0];
      div_cnt <= div_cnt + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      level        <= level_now;
      target_level <= level_goal;
      fading       <= fade_on;
      auto_armed   <= auto_on;
      manual_hold  <= hold_manual;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/led_fade_with_auto_off_unit.sv
// ----------------------------------------------------------------------------
// led_fade_with_auto_off_unit
// LED dimmer that ramps a level toward a rounded target, with auto-off timer.
// ----------------------------------------------------------------------------
//  Channel  Direction  Transfer condition             Payload
//  s_*      in         s_tvalid & s_tready            command, target_value
//  m_*      out        m_tvalid & m_tready            level, target, flags
//  APB      in         psel & penable & pwrite        4 config registers
//
//  A tick passes through count, step and emit before the next accept. Set
//  target and toggle pass through divide, goal and emit: the rounding remainder
//  is found one bit per cycle by a restoring divider. Others use apply and emit.
//  Synchronous reset returns the fader and the registers to their defaults.
//  A stalled output holds its result; one further item is taken and waits.
// ----------------------------------------------------------------------------
`default_nettype none

module led_fade_with_auto_off_unit
  import lfade_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [2:0] command, [10:3] target_value
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [23:0] m_tdata,   // [7:0] level, [15:8] target_level, [16] fading,
                                      // [17] auto_armed, [18] manual_hold
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  cfg_t       cfg;
  dp_cmd_t    dp_cmd;
  dp_stat_t   dp_stat;
  cmd_t       in_cmd;
  logic [7:0] level;
  logic [7:0] target_level;
  logic       fading;
  logic       auto_armed;
  logic       manual_hold;

  assign in_cmd  = cmd_t'(s_tdata[2:0]);
  assign m_tdata = {5'd0, manual_hold, auto_armed, fading, target_level, level};

  lfade_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lfade_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_cmd    (in_cmd),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  lfade_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (dp_cmd),
    .stat         (dp_stat),
    .in_command   (in_cmd),
    .in_target    (s_tdata[10:3]),
    .cfg          (cfg),
    .level        (level),
    .target_level (target_level),
    .fading       (fading),
    .auto_armed   (auto_armed),
    .manual_hold  (manual_hold)
  );

endmodule

`default_nettype wire

FILE: rtl/core/lfade_checker.sv
// ----------------------------------------------------------------------------
// lfade_checker
// Port-level checks of the LED fader, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lfade_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid straight after reset");

  // one item in work at a time
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken while busy");

  // auto-off timer and manual hold exclude each other
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[17] && m_tdata[18]))
    else $error("auto_armed and manual_hold both set");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[23:19] == 5'd0)
    else $error("result padding not zero");

endmodule

bind led_fade_with_auto_off_unit lfade_checker u_lfade_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

FILE: tb/tb_led_fade_with_auto_off_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_led_fade_with_auto_off_unit
// Self-checking bench for the LED fader with auto-off timer. Commands go in on
// the slave stream and each transfer is predicted by a behavioural copy of the
// fader. The status that comes back on the master stream is compared field by
// field. Register writes happen only with the fader idle and are read back.
// ----------------------------------------------------------------------------

module tb_led_fade_with_auto_off_unit;
  import lfade_pkg::*;

  localparam int IDLE_LIMIT    = 5000;
  localparam int SETTLE_CYCLES = 20;
  localparam logic [2:0] CMD_UNUSED = 3'd7;

  typedef struct {
    logic [7:0] level;
    logic [7:0] target;
    logic       fading;
    logic       auto_armed;
    logic       manual_hold;
  } fader_status_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // [2:0] command, [10:3] target_value
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // [7:0] level, [15:8] target_level, [16] fading,
                               // [17] auto_armed, [18] manual_hold
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int idle_cycles = 0;

  fader_status_t expected_status_q[$];

  // Predicted settings and fader state
  logic [7:0]  step_reg     = 8'd5;
  logic [7:0]  max_reg      = 8'd255;
  logic [15:0] interval_reg = 16'd10;
  logic [31:0] timeout_reg  = 32'd60000;
  logic [7:0]  level_q      = '0;
  logic [7:0]  goal_q       = '0;
  logic        fading_q     = 1'b0;
  logic [15:0] fade_cnt     = '0;
  logic        armed_q      = 1'b0;
  logic [31:0] armed_cnt    = '0;
  logic        hold_q       = 1'b0;

  always #5 clk = ~clk;

  led_fade_with_auto_off_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // ---------------------------------------------------------------- predictor
  function automatic int unsigned step_size();
    return (step_reg == 8'd0) ? 1 : int'(step_reg);
  endfunction

  function automatic void set_goal(input int unsigned v);
    int unsigned s;
    s = step_size();
    if (v > max_reg) v = max_reg;
    goal_q = 8'((v / s) * s);
  endfunction

  function automatic void start_fade(input logic is_auto);
    fading_q = 1'b1;
    fade_cnt = '0;
    if (is_auto && !hold_q) begin
      armed_q   = 1'b1;
      armed_cnt = '0;
      hold_q    = 1'b0;
    end else begin
      armed_q = 1'b0;
      hold_q  = 1'b1;
    end
  endfunction

  function automatic void advance_tick();
    int unsigned s, now, goal;
    if (fading_q && fade_cnt != 16'hFFFF) fade_cnt++;
    if (armed_q) begin
      if (armed_cnt != 32'hFFFF_FFFF) armed_cnt++;
      if (armed_cnt >= timeout_reg) begin
        set_goal(0);
        start_fade(1'b0);
      end
    end
    if (fading_q && fade_cnt >= interval_reg) begin
      s    = step_size();
      now  = level_q;
      goal = goal_q;
      // snap onto the target when within one step
      if (now < goal) now = (goal - now <= s) ? goal : now + s;
      else if (now > goal) now = (now - goal <= s) ? goal : now - s;
      level_q = 8'(now);
      if (now == goal) begin
        fading_q = 1'b0;
        hold_q   = 1'b0;
      end
      fade_cnt = '0;
    end
  endfunction

  function automatic fader_status_t fader_apply(input logic [2:0] cmd, input logic [7:0] value);
    fader_status_t st;
    case (cmd)
      CMD_TICK:   advance_tick();
      CMD_SET:    set_goal(value);
      CMD_MANUAL: start_fade(1'b0);
      CMD_AUTO:   start_fade(1'b1);
      CMD_TOGGLE: begin
        if (goal_q != 8'd0) set_goal(0);
        else set_goal(max_reg);
        start_fade(1'b0);
      end
      CMD_ON:     level_q = FULL_LEVEL;
      CMD_OFF:    level_q = 8'd0;
      default: ;
    endcase
    st.level       = level_q;
    st.target      = goal_q;
    st.fading      = fading_q;
    st.auto_armed  = armed_q;
    st.manual_hold = hold_q;
    return st;
  endfunction

  // ---------------------------------------------------------------- checking
  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    fader_status_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (expected_status_q.size() == 0) begin
        $error("status transfer with nothing expected: %h", m_tdata);
        errors++;
      end else begin
        want = expected_status_q.pop_front();
        check_field("level", want.level, m_tdata[7:0]);
        check_field("target_level", want.target, m_tdata[15:8]);
        check_field("fading", want.fading, m_tdata[16]);
        check_field("auto_armed", want.auto_armed, m_tdata[17]);
        check_field("manual_hold", want.manual_hold, m_tdata[18]);
      end
    end
  end

  always @(posedge clk) begin
    m_tready <= rst ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[led_fade_with_auto_off_unit] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- drivers
  // Leave tvalid high on return so back-to-back transfers need no glitch.
  task automatic send_item(input logic [2:0] cmd, input logic [7:0] value);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'd0, value, cmd};
    do @(posedge clk); while (!s_tready);
    expected_status_q.push_back(fader_apply(cmd, value));
    items_sent++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] mask;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_FADE_STEP:     begin step_reg = value[7:0];      mask = 32'h0000_00FF; end
      REG_MAX_LEVEL:     begin max_reg = value[7:0];       mask = 32'h0000_00FF; end
      REG_FADE_INTERVAL: begin interval_reg = value[15:0]; mask = 32'h0000_FFFF; end
      default:           begin timeout_reg = value;        mask = 32'hFFFF_FFFF; end
    endcase
    // back-to-back read of the same register
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== (value & mask)) begin
      $error("prdata at %0d: expected %h, got %h", {idx, 2'b00}, value & mask, prdata);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [7:0] step, input logic [7:0] max_lvl,
                               input logic [15:0] interval, input logic [31:0] timeout);
    write_reg(REG_FADE_STEP, step);
    write_reg(REG_MAX_LEVEL, max_lvl);
    write_reg(REG_FADE_INTERVAL, interval);
    write_reg(REG_AUTO_TIMEOUT, timeout);
  endtask

  function automatic logic [7:0] pick_level();
    case ($urandom_range(7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Mostly set-fade-tick runs so fades complete and timers expire; rest is noise.
  task automatic run_traffic(input int n_items);
    int sent, n_ticks;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 70) begin
        n_ticks = $urandom_range(2, 30);
        send_item(CMD_SET, pick_level());
        send_item($urandom_range(1) ? CMD_AUTO : CMD_MANUAL, pick_level());
        repeat (n_ticks) send_item(CMD_TICK, 8'($urandom_range(255)));
        sent += n_ticks + 2;
      end else begin
        send_item(3'($urandom_range(7)), pick_level());
        sent++;
      end
    end
    wait_idle();
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_commands_at_reset_settings();
    send_item(CMD_SET, 8'd254);
    send_item(CMD_SET, 8'd0);
    send_item(CMD_TOGGLE, 8'd0);
    send_item(CMD_AUTO, 8'd0);
    send_item(CMD_TICK, 8'd255);
    send_item(CMD_ON, 8'd0);
    send_item(CMD_OFF, 8'd0);
    send_item(CMD_UNUSED, 8'hAA);
    send_item(CMD_TOGGLE, 8'h55);
    send_item(CMD_SET, 8'd255);
    wait_idle();
  endtask

  task automatic test_zero_settings();
    // zero interval steps every tick, zero timeout expires at once
    write_reg(REG_FADE_INTERVAL, 16'd0);
    write_reg(REG_AUTO_TIMEOUT, 32'd0);
    send_item(CMD_ON, 8'd0);
    send_item(CMD_TICK, 8'd0);
    send_item(CMD_AUTO, 8'd0);
    send_item(CMD_TICK, 8'd0);
    wait_idle();
    // zero step acts as a step of one
    write_reg(REG_FADE_STEP, 8'd0);
    send_item(CMD_SET, 8'd137);
    send_item(CMD_MANUAL, 8'd0);
    send_item(CMD_TICK, 8'd0);
    send_item(CMD_TICK, 8'd0);
    wait_idle();
    // zero max forces every target to zero
    write_reg(REG_MAX_LEVEL, 8'd0);
    send_item(CMD_SET, 8'd255);
    send_item(CMD_TOGGLE, 8'd0);
    send_item(CMD_TICK, 8'd0);
    wait_idle();
  endtask

  task automatic test_typical_traffic(input int n_items);
    load_settings(8'($urandom_range(1, 20)), 8'($urandom_range(1, 255)),
                  16'($urandom_range(1, 4)), 32'($urandom_range(3, 40)));
    run_traffic(n_items);
  endtask

  task automatic test_extreme_settings();
    load_settings(8'd255, 8'd255, 16'hFFFF, 32'hFFFF_FFFF);
    run_traffic(40);
    load_settings(8'd1, 8'd1, 16'd1, 32'd1);
    run_traffic(60);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 17;
    recv_idle_pct = 74;
    test_commands_at_reset_settings();
    test_zero_settings();
    test_typical_traffic(170);

    send_idle_pct = 74;
    recv_idle_pct = 17;
    test_extreme_settings();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_typical_traffic(230);

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Checked %0d status transfers for %0d commands, all seven commands and code 7,",
             results_seen, items_sent);
    $display("zero, full-scale and random register settings, with uneven stalls on both sides.");
    if (errors == 0) begin
      $display("[led_fade_with_auto_off_unit] OK");
    end else begin
      $display("[led_fade_with_auto_off_unit] ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/lfade_pkg.sv
rtl/core/lfade_regs.sv
rtl/core/lfade_ctrl.sv
rtl/core/lfade_dp.sv
rtl/core/led_fade_with_auto_off_unit.sv
rtl/core/lfade_checker.sv
tb/tb_led_fade_with_auto_off_unit.sv
